[hdl/ps2_mouse_packet_cursor_assert.svh]
// Assertion macros for the PS/2 mouse packet cursor block.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef PS2_MOUSE_PACKET_CURSOR_ASSERT_SVH
`define PS2_MOUSE_PACKET_CURSOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMPC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pmpc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PMPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pmpc: next-cycle check failed");

`endif

[hdl/pmpc_pkg.sv]
package pmpc_pkg;

  localparam int unsigned POS_BITS_DEF = 12;
  localparam int unsigned STEP_W       = 8;
  localparam int unsigned LIMIT_W      = 12;
  localparam int unsigned MOVE_W       = 9;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned ADDR_W       = 4;
  localparam int unsigned DATA_W       = 32;

  // Status byte bit positions.
  localparam int unsigned BIT_OVF_Y = 7;
  localparam int unsigned BIT_OVF_X = 6;
  localparam int unsigned BIT_NEG_Y = 5;
  localparam int unsigned BIT_NEG_X = 4;
  localparam int unsigned BIT_SYNC  = 3;
  localparam int unsigned BIT_MID   = 2;
  localparam int unsigned BIT_RIGHT = 1;
  localparam int unsigned BIT_LEFT  = 0;

  localparam logic [STEP_W-1:0]  MOVE_STEP_RST = 8'd1;
  localparam logic [LIMIT_W-1:0] X_LIMIT_RST   = 12'd1016;
  localparam logic [LIMIT_W-1:0] Y_LIMIT_RST   = 12'd752;

  typedef enum logic [1:0] {
    REG_MOVE_STEP = 2'd0,
    REG_X_LIMIT   = 2'd1,
    REG_Y_LIMIT   = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    IDX_STATUS = 2'd0,
    IDX_XBYTE  = 2'd1,
    IDX_YBYTE  = 2'd2
  } byte_idx_e;

endpackage

[hdl/pmpc_byte_if.sv]
interface pmpc_byte_if;
  import pmpc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

[hdl/pmpc_cursor_if.sv]
interface pmpc_cursor_if #(
  parameter int unsigned POS_BITS = pmpc_pkg::POS_BITS_DEF
);
  import pmpc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [POS_BITS-1:0]      pos_x;
  logic [POS_BITS-1:0]      pos_y;
  logic signed [MOVE_W-1:0] move_x;
  logic signed [MOVE_W-1:0] move_y;
  logic                     left_button;
  logic                     right_button;
  logic                     middle_button;
  logic                     dropped;

  modport source (
    output valid, output pos_x, output pos_y, output move_x, output move_y,
    output left_button, output right_button, output middle_button, output dropped,
    input ready
  );
  modport sink (
    input valid, input pos_x, input pos_y, input move_x, input move_y,
    input left_button, input right_button, input middle_button, input dropped,
    output ready
  );
endinterface

[hdl/ps2_mouse_packet_cursor.sv]
// PS/2 mouse packet decoder with a clamped pointer position.
// byte_i carries one mouse byte per word. A status byte starts a packet only when
// its always-one bit is set; it is followed by the X and Y movement bytes. The third
// byte of a packet produces one word on cursor_o: position, last moves, buttons
// and a dropped flag for packets with an overflow bit (those leave the state as
// it was). Status and X bytes produce nothing.
// Latency: the result word is valid in the cycle after the third byte is taken.
// Throughput: one byte per cycle; the decode is a single add and clamp per axis
// from the held status and X bytes and the live Y byte to the result register.
// When cursor_o stalls, status and X bytes are still taken; a Y byte waits only
// while the result register holds a word that is not being taken that cycle.
// Reset clears the packet position, cursor, moves and buttons and loads the
// register defaults (step 1, x limit 1016, y limit 752); the output is empty.
// The APB port (psel, penable, pwrite, paddr, pwdata, prdata, pready) holds
// move_step at 0x0, x_limit at 0x4 and y_limit at 0x8; pready is always high.
module ps2_mouse_packet_cursor #(
  parameter int unsigned POS_BITS = pmpc_pkg::POS_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  pmpc_byte_if.sink                    byte_i,
  pmpc_cursor_if.source                cursor_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pmpc_pkg::ADDR_W-1:0]  paddr,
  input  logic [pmpc_pkg::DATA_W-1:0]  pwdata,
  output logic [pmpc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import pmpc_pkg::*;

  localparam int unsigned LX = (POS_BITS > LIMIT_W) ? POS_BITS : LIMIT_W;
  localparam int unsigned SW = POS_BITS + 2;

  // Configuration registers.
  logic [STEP_W-1:0]  move_step_q;
  logic [LIMIT_W-1:0] x_limit_q, y_limit_q;

  // Packet and pointer state.
  logic [1:0]               idx_q, idx_d;
  logic [BYTE_W-1:0]        stat_q, xb_q;
  logic [POS_BITS-1:0]      cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [MOVE_W-1:0] mv_x_q, mv_x_d, mv_y_q, mv_y_d;
  logic [2:0]               btn_q, btn_d;

  // Result register.
  logic                     out_valid_q, out_valid_d;
  logic [POS_BITS-1:0]      out_x_q, out_y_q;
  logic signed [MOVE_W-1:0] out_mv_x_q, out_mv_y_q;
  logic [2:0]               out_btn_q;
  logic                     out_drop_q;

  logic                in_fire, last_byte, ovf, cfg_wr;
  logic [POS_BITS-1:0] hi_x, hi_y, ax_x, ax_y;
  logic signed [MOVE_W-1:0] am_x, am_y;

  function automatic logic [POS_BITS-1:0] eff_limit(input logic [LIMIT_W-1:0] lim);
    logic [LX-1:0] lim_ext;
    logic [LX-1:0] pmax;
    lim_ext = LX'(lim);
    pmax    = LX'({POS_BITS{1'b1}});
    return (lim_ext > pmax) ? pmax[POS_BITS-1:0] : lim_ext[POS_BITS-1:0];
  endfunction

  // One axis: optional step up or down, then clamp to 0..hi.
  function automatic void axis_update(
    input  logic [POS_BITS-1:0]      pos,
    input  logic signed [MOVE_W-1:0] mv,
    input  logic                     inc,
    input  logic                     dec,
    input  logic [STEP_W-1:0]        step,
    input  logic [POS_BITS-1:0]      hi,
    output logic [POS_BITS-1:0]      pos_n,
    output logic signed [MOVE_W-1:0] mv_n
  );
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] step_s;
    step_s = signed'(SW'(step));
    sum    = signed'({2'b00, pos});
    mv_n   = mv;
    if (dec) begin
      sum  = sum - step_s;
      mv_n = -signed'({1'b0, step});
    end else if (inc) begin
      sum  = sum + step_s;
      mv_n = signed'({1'b0, step});
    end
    if (sum < 0) begin
      pos_n = '0;
      mv_n  = '0;
    end else if (sum > signed'({2'b00, hi})) begin
      pos_n = hi;
      mv_n  = '0;
    end else begin
      pos_n = sum[POS_BITS-1:0];
    end
  endfunction

  // The index never reaches three; if it did, it would act as the Y byte.
  assign last_byte    = idx_q[1];
  assign byte_i.ready = !last_byte || !out_valid_q || cursor_o.ready;
  assign in_fire      = byte_i.valid && byte_i.ready;
  assign ovf          = stat_q[BIT_OVF_X] || stat_q[BIT_OVF_Y];

  assign hi_x = eff_limit(x_limit_q);
  assign hi_y = eff_limit(y_limit_q);

  always_comb begin
    axis_update(cur_x_q, mv_x_q, !stat_q[BIT_NEG_X] && (xb_q != '0), stat_q[BIT_NEG_X],
                move_step_q, hi_x, ax_x, am_x);
    // Screen y grows downwards, so the mouse's sign is inverted.
    axis_update(cur_y_q, mv_y_q, stat_q[BIT_NEG_Y],
                !stat_q[BIT_NEG_Y] && (byte_i.data_byte != '0),
                move_step_q, hi_y, ax_y, am_y);
  end

  always_comb begin
    idx_d   = idx_q;
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    mv_x_d  = mv_x_q;
    mv_y_d  = mv_y_q;
    btn_d   = btn_q;
    if (in_fire) begin
      priority if (last_byte) begin
        idx_d = IDX_STATUS;
        if (!ovf) begin
          cur_x_d = ax_x;
          cur_y_d = ax_y;
          mv_x_d  = am_x;
          mv_y_d  = am_y;
          btn_d   = stat_q[BIT_MID:BIT_LEFT];
        end
      end else if (idx_q == IDX_XBYTE) begin
        idx_d = IDX_YBYTE;
      end else if (byte_i.data_byte[BIT_SYNC]) begin
        idx_d = IDX_XBYTE;
      end else begin
        // A status byte without the always-one bit is thrown away.
        idx_d = IDX_STATUS;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire && last_byte) begin
      out_valid_d = 1'b1;
    end else if (cursor_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= IDX_STATUS;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      mv_x_q      <= '0;
      mv_y_q      <= '0;
      btn_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      mv_x_q      <= mv_x_d;
      mv_y_q      <= mv_y_d;
      btn_q       <= btn_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && (idx_q == IDX_STATUS)) begin
      stat_q <= byte_i.data_byte;
    end
    if (in_fire && (idx_q == IDX_XBYTE)) begin
      xb_q <= byte_i.data_byte;
    end
    if (in_fire && last_byte) begin
      out_x_q    <= cur_x_d;
      out_y_q    <= cur_y_d;
      out_mv_x_q <= mv_x_d;
      out_mv_y_q <= mv_y_d;
      out_btn_q  <= btn_d;
      out_drop_q <= ovf;
    end
  end

  assign cursor_o.valid         = out_valid_q;
  assign cursor_o.pos_x         = out_x_q;
  assign cursor_o.pos_y         = out_y_q;
  assign cursor_o.move_x        = out_mv_x_q;
  assign cursor_o.move_y        = out_mv_y_q;
  assign cursor_o.left_button   = out_btn_q[BIT_LEFT];
  assign cursor_o.right_button  = out_btn_q[BIT_RIGHT];
  assign cursor_o.middle_button = out_btn_q[BIT_MID];
  assign cursor_o.dropped       = out_drop_q;

  // Register port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      move_step_q <= MOVE_STEP_RST;
      x_limit_q   <= X_LIMIT_RST;
      y_limit_q   <= Y_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MOVE_STEP: move_step_q <= pwdata[STEP_W-1:0];
        REG_X_LIMIT:   x_limit_q   <= pwdata[LIMIT_W-1:0];
        REG_Y_LIMIT:   y_limit_q   <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MOVE_STEP: prdata = DATA_W'(move_step_q);
      REG_X_LIMIT:   prdata = DATA_W'(x_limit_q);
      REG_Y_LIMIT:   prdata = DATA_W'(y_limit_q);
      default:       prdata = '0;
    endcase
  end

  `include "ps2_mouse_packet_cursor_assert.svh"

  `PMPC_ASSERT_NEXT(a_result_follows_y_byte, in_fire && last_byte, out_valid_q)
  `PMPC_ASSERT_NEXT(a_dropped_keeps_cursor, in_fire && last_byte && ovf,
                    (cur_x_q == $past(cur_x_q)) && (cur_y_q == $past(cur_y_q)))
  `PMPC_ASSERT_NEXT(a_cursor_within_limit, in_fire && last_byte && !ovf,
                    (cur_x_q <= $past(hi_x)) && (cur_y_q <= $past(hi_y)))
  `PMPC_ASSERT_SAME(a_stall_only_on_y_byte, !byte_i.ready,
                    last_byte && out_valid_q && !cursor_o.ready)

endmodule

[sim/pmpc_cursor_checker.sv]
module pmpc_cursor_checker #(
  parameter int unsigned POS_BITS = pmpc_pkg::POS_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  pmpc_byte_if                        byte_mon,
  pmpc_cursor_if                      cursor_mon,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pmpc_pkg::ADDR_W-1:0] paddr,
  input  logic [pmpc_pkg::DATA_W-1:0] pwdata,
  input  logic                        pready,
  output int                          words_due,
  output int                          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import pmpc_pkg::*;

  localparam int POS_TOP = (1 << POS_BITS) - 1;

  typedef struct packed {
    logic [POS_BITS-1:0]      pos_x;
    logic [POS_BITS-1:0]      pos_y;
    logic signed [MOVE_W-1:0] move_x;
    logic signed [MOVE_W-1:0] move_y;
    logic                     left_btn;
    logic                     right_btn;
    logic                     mid_btn;
    logic                     dropped;
  } cursor_word_t;

  cursor_word_t       cursor_due[$];
  cursor_word_t       seen;
  cursor_word_t       want;
  cursor_word_t       fresh;
  logic [STEP_W-1:0]  step_cfg;
  logic [LIMIT_W-1:0] xlim_cfg;
  logic [LIMIT_W-1:0] ylim_cfg;
  byte_idx_e          pkt_pos;
  logic [BYTE_W-1:0]  status_b;
  logic [BYTE_W-1:0]  xmove_b;
  logic [2:0]         btn_bits;
  int                 ptr_x;
  int                 ptr_y;
  int                 mv_x;
  int                 mv_y;
  int                 dir_x;
  int                 dir_y;
  int                 errs = 0;

  assign fail_count = errs;

  // Moves one axis by a whole step in the given direction, then pins it to 0..lim, or below lim to the top position.
  // A direction of zero leaves the stored move alone unless the clamp bites.
  function automatic void step_axis(inout int pos, inout int mv, input int dir,
                                    input int lim, input int stride);
    int top;
    top = (lim > POS_TOP) ? POS_TOP : lim;
    if (dir > 0) begin
      pos += stride;
      mv = stride;
    end else if (dir < 0) begin
      pos -= stride;
      mv = -stride;
    end
    if (pos < 0) begin
      pos = 0;
      mv = 0;
    end else if (pos > top) begin
      pos = top;
      mv = 0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_cfg = MOVE_STEP_RST;
      xlim_cfg = X_LIMIT_RST;
      ylim_cfg = Y_LIMIT_RST;
      pkt_pos  = IDX_STATUS;
      status_b = '0;
      xmove_b  = '0;
      btn_bits = '0;
      ptr_x    = 0;
      ptr_y    = 0;
      mv_x     = 0;
      mv_y     = 0;
      cursor_due.delete();
    end else begin
      if (cursor_mon.valid && cursor_mon.ready) begin
        seen.pos_x     = cursor_mon.pos_x;
        seen.pos_y     = cursor_mon.pos_y;
        seen.move_x    = cursor_mon.move_x;
        seen.move_y    = cursor_mon.move_y;
        seen.left_btn  = cursor_mon.left_button;
        seen.right_btn = cursor_mon.right_button;
        seen.mid_btn   = cursor_mon.middle_button;
        seen.dropped   = cursor_mon.dropped;
        if (cursor_due.size() == 0) begin
          errs++;
          if (errs <= 10) begin
            $display("%0t: cursor word with nothing expected: x=%0d y=%0d drop=%b",
                     $realtime, seen.pos_x, seen.pos_y, seen.dropped);
          end
        end else begin
          want = cursor_due.pop_front();
          if (seen !== want) begin
            errs++;
            if (errs <= 10) begin
              $display("%0t: cursor word mismatch", $realtime);
              $display("  expected x=%0d y=%0d mx=%0d my=%0d lrm=%b%b%b drop=%b",
                       want.pos_x, want.pos_y, want.move_x, want.move_y,
                       want.left_btn, want.right_btn, want.mid_btn, want.dropped);
              $display("  actual   x=%0d y=%0d mx=%0d my=%0d lrm=%b%b%b drop=%b",
                       seen.pos_x, seen.pos_y, seen.move_x, seen.move_y,
                       seen.left_btn, seen.right_btn, seen.mid_btn, seen.dropped);
            end
          end
        end
      end

      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[ADDR_W-1:2]))
          REG_MOVE_STEP: step_cfg = pwdata[STEP_W-1:0];
          REG_X_LIMIT:   xlim_cfg = pwdata[LIMIT_W-1:0];
          REG_Y_LIMIT:   ylim_cfg = pwdata[LIMIT_W-1:0];
          default: ;
        endcase
      end

      if (byte_mon.valid && byte_mon.ready) begin
        case (pkt_pos)
          IDX_STATUS: begin
            // Without the always-one bit the word cannot open a packet.
            if (byte_mon.data_byte[BIT_SYNC]) begin
              status_b = byte_mon.data_byte;
              pkt_pos  = IDX_XBYTE;
            end
          end
          IDX_XBYTE: begin
            xmove_b = byte_mon.data_byte;
            pkt_pos = IDX_YBYTE;
          end
          default: begin
            pkt_pos = IDX_STATUS;
            fresh.dropped = status_b[BIT_OVF_X] | status_b[BIT_OVF_Y];
            if (!fresh.dropped) begin
              btn_bits = status_b[BIT_MID:BIT_LEFT];
              dir_x = status_b[BIT_NEG_X] ? -1 : ((xmove_b != 0) ? 1 : 0);
              // Screen y grows downwards, so the mouse moving up means a smaller y.
              dir_y = status_b[BIT_NEG_Y] ? 1 : ((byte_mon.data_byte != 0) ? -1 : 0);
              step_axis(ptr_x, mv_x, dir_x, int'(xlim_cfg), int'(step_cfg));
              step_axis(ptr_y, mv_y, dir_y, int'(ylim_cfg), int'(step_cfg));
            end
            fresh.pos_x     = POS_BITS'(ptr_x);
            fresh.pos_y     = POS_BITS'(ptr_y);
            fresh.move_x    = MOVE_W'(mv_x);
            fresh.move_y    = MOVE_W'(mv_y);
            fresh.left_btn  = btn_bits[BIT_LEFT];
            fresh.right_btn = btn_bits[BIT_RIGHT];
            fresh.mid_btn   = btn_bits[BIT_MID];
            cursor_due.push_back(fresh);
          end
        endcase
      end
    end
    words_due <= cursor_due.size();
  end

endmodule

[sim/tb_ps2_mouse_packet_cursor.sv]
module tb_ps2_mouse_packet_cursor;
  timeunit 1ns;
  timeprecision 1ps;
  import pmpc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_BYTES = 204;
  localparam int HOLD_CYCLES = 300;

  // Stray words first, then packets covering buttons, zero moves, signed zeros
  // and every combination of overflow bits.
  localparam logic [7:0] OPENING [23] = '{
    8'h00, 8'hF7,
    8'h0F, 8'h00, 8'h00,
    8'h08, 8'hFF, 8'hFF,
    8'h38, 8'h00, 8'h00,
    8'h3A, 8'h7F, 8'h01,
    8'hC8, 8'h55, 8'hAA,
    8'h4C, 8'h10, 8'h20,
    8'h8B, 8'h01, 8'h01
  };

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic              pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  int                words_due;
  int                fail_count;
  int                cycles = 0;
  bit                idle_on = 1'b1;
  int                holds_asked = 0;
  int                holds_done = 0;
  int                hold_left = 0;

  pmpc_byte_if   byte_bus ();
  pmpc_cursor_if cursor_bus ();

  ps2_mouse_packet_cursor u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_bus),
    .cursor_o (cursor_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  pmpc_cursor_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_mon   (byte_bus),
    .cursor_mon (cursor_bus),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .words_due  (words_due),
    .fail_count (fail_count)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_ps2_mouse_packet_cursor: errors");
      $finish;
    end
  end

  // Cursor receiver: random stalls, plus long hold-offs so that the block backs up.
  initial begin
    cursor_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_done != holds_asked) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        cursor_bus.ready <= 1'b0;
      end else begin
        cursor_bus.ready <= !(idle_on && $urandom_range(99) < 9);
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while (idle_on && $urandom_range(99) < 9) begin
      byte_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_bus.valid     <= 1'b1;
    byte_bus.data_byte <= b;
    do @(posedge clk_i); while (!byte_bus.ready);
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    byte_bus.valid <= 1'b0;
    do @(posedge clk_i); while (words_due != 0);
    // A status or X word may still be sitting in the byte stage.
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [STEP_W-1:0] st, input logic [LIMIT_W-1:0] xl,
                          input logic [LIMIT_W-1:0] yl);
    drain();
    reg_write(REG_MOVE_STEP, DATA_W'(st));
    reg_write(REG_X_LIMIT, DATA_W'(xl));
    reg_write(REG_Y_LIMIT, DATA_W'(yl));
  endtask

  function automatic logic [BYTE_W-1:0] move_byte();
    return ($urandom_range(99) < 15) ? '0 : BYTE_W'($urandom);
  endfunction

  initial begin
    int                sent;
    logic [BYTE_W-1:0] status;
    rst_ni             <= 1'b0;
    byte_bus.valid     <= 1'b0;
    byte_bus.data_byte <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (OPENING[i]) send_byte(OPENING[i]);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_regs(8'd255, 12'd4095, 12'd4095);
        // Limits dropped under the current position: the next undropped packet must pull it in.
        1: set_regs(8'd255, 12'd0, 12'd0);
        2: set_regs(8'd0, 12'd4095, 12'd4095);
        3: set_regs(MOVE_STEP_RST, X_LIMIT_RST, Y_LIMIT_RST);
        4: set_regs(STEP_W'($urandom), LIMIT_W'($urandom), LIMIT_W'($urandom));
        5: set_regs(STEP_W'($urandom_range(15)), LIMIT_W'($urandom_range(63)),
                    LIMIT_W'($urandom_range(63)));
        6: set_regs(STEP_W'($urandom_range(255, 1)), LIMIT_W'($urandom_range(600)),
                    LIMIT_W'($urandom_range(600)));
        default: set_regs(8'd128, 12'd2048, 12'd100);
      endcase
      idle_on = (ph != 3);
      if (ph == 1 || ph == 6) holds_asked++;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        // Mostly well-formed packets; the odd stray word knocks the framing about.
        if ($urandom_range(99) < 8) begin
          send_byte(BYTE_W'($urandom));
          sent++;
        end else begin
          status = BYTE_W'($urandom);
          status[BIT_SYNC] = 1'b1;
          if ($urandom_range(99) >= 8) status[BIT_OVF_Y:BIT_OVF_X] = 2'b00;
          send_byte(status);
          send_byte(move_byte());
          send_byte(move_byte());
          sent += 3;
        end
      end
    end
    idle_on = 1'b1;

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_ps2_mouse_packet_cursor: clean");
    end else begin
      $display("tb_ps2_mouse_packet_cursor: errors");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/pmpc_pkg.sv
hdl/pmpc_byte_if.sv
hdl/pmpc_cursor_if.sv
hdl/ps2_mouse_packet_cursor.sv
sim/pmpc_cursor_checker.sv
sim/tb_ps2_mouse_packet_cursor.sv
